>>> hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the telemetry frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0] EscByte   = 8'h7d;
  localparam logic [7:0] EscOffset = 8'h20;
  localparam logic [7:0] FrameByte = 8'h10;
  localparam logic [7:0] CheckBase = 8'hff;

  localparam int unsigned PayloadBytes = 6;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [2:0] PosIdle  = 3'd0;
  localparam logic [2:0] PosCheck = 3'd7;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_in_datagram;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sensor_id;
    logic [31:0] sensor_value;
  } out_item_t;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic  valid;
    byte_t data;
  } byte_xfer_t;

endpackage

>>> hdl/sfd_fifo.sv
// ----------------------------------------------------------------------------
// sfd_fifo
// Small register queue with a full and an empty flag.
// ----------------------------------------------------------------------------
module sfd_fifo #(
  parameter int unsigned Depth = 2,
  parameter type data_t = logic [7:0]
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  data_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output data_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  data_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_fire;
  logic             pop_fire;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign push_fire = push_i && !full_o;
  assign pop_fire  = pop_i && !empty_o;
  assign data_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_fire && !pop_fire) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_fire && !push_fire) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Accepts raw link bytes, removes escape bytes and restores escaped data.
// ----------------------------------------------------------------------------
module sfd_front
  import sfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  in_item_t   in_data_i,
  output byte_xfer_t byte_o
);

  logic  esc_pending_q, esc_pending_d;
  logic  is_esc;
  byte_t decoded;

  assign is_esc  = !esc_pending_q && (in_data_i.rx_byte == EscByte);
  assign decoded = esc_pending_q ? byte_t'(in_data_i.rx_byte + EscOffset)
                                 : in_data_i.rx_byte;

  always_comb begin
    esc_pending_d = esc_pending_q;
    byte_o.valid  = 1'b0;
    byte_o.data   = decoded;
    if (in_fire_i) begin
      if (is_esc) begin
        esc_pending_d = 1'b1;
      end else begin
        esc_pending_d = 1'b0;
        byte_o.valid  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_pending_q <= 1'b0;
    end else begin
      esc_pending_q <= esc_pending_d;
    end
  end

endmodule

>>> hdl/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Frame parser: tracks the frame position, the running check sum and the
// payload, and issues a result for each frame whose check byte matches.
// ----------------------------------------------------------------------------
module sfd_back
  import sfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      byte_valid_i,
  input  byte_t     byte_i,
  output logic      byte_ready_o,
  output logic      res_valid_o,
  output out_item_t res_o,
  input  logic      res_ready_i
);

  localparam int unsigned PayloadW = PayloadBytes * 8;

  logic [2:0]          pos_q, pos_d;
  byte_t               sum_q, sum_d;
  logic [PayloadW-1:0] payload_q, payload_d;
  logic [8:0]          sum_wide;
  logic                fire;

  assign byte_ready_o = res_ready_i;
  assign fire         = byte_valid_i && res_ready_i;
  assign sum_wide     = {1'b0, sum_q} + {1'b0, byte_i};

  assign res_o.sensor_id    = payload_q[15:0];
  assign res_o.sensor_value = payload_q[PayloadW-1:16];

  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    payload_d   = payload_q;
    res_valid_o = 1'b0;
    if (fire) begin
      if (pos_q == PosIdle) begin
        if (byte_i == FrameByte) begin
          sum_d = FrameByte;
          pos_d = 3'd1;
        end
      end else if (pos_q == PosCheck) begin
        pos_d       = PosIdle;
        res_valid_o = (byte_t'(CheckBase - sum_q) == byte_i);
      end else begin
        payload_d = {byte_i, payload_q[PayloadW-1:8]};
        sum_d     = sum_wide[7:0] + byte_t'(sum_wide[8]);
        pos_d     = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosIdle;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
  end

endmodule

>>> hdl/smartport_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// smartport_frame_deframer_unit
// Telemetry deframer: unstuffs the received byte stream, parses data frames
// and delivers sensor id and raw value for each frame with a valid check.
// ----------------------------------------------------------------------------
//   Channel   Handshake      Payload
//   input     push / full    in_data_i  (rx_byte, last_in_datagram)
//   result    pop / empty    out_data_o (sensor_id, sensor_value)
//
// One byte is taken per cycle while full is low; a byte queue separates
// unstuffing from parsing. A result is written into the result queue at the
// edge that accepts its check byte.
// Parsing stalls only when the result queue is full; full then follows once
// the byte queue has filled.
// Reset clears the escape flag, frame position and both queues.
module smartport_frame_deframer_unit
  import sfd_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data_i,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data_o
);

  byte_xfer_t front_byte;
  byte_t      mid_data;
  logic       mid_empty;
  logic       back_ready;
  logic       res_valid;
  out_item_t  res_data;
  logic       res_full;

  sfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (push && !full),
    .in_data_i (in_data_i),
    .byte_o    (front_byte)
  );

  sfd_fifo #(
    .Depth  (QDepth),
    .data_t (byte_t)
  ) u_byte_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_byte.valid),
    .data_i  (front_byte.data),
    .full_o  (full),
    .pop_i   (back_ready),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  sfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (!mid_empty),
    .byte_i       (mid_data),
    .byte_ready_o (back_ready),
    .res_valid_o  (res_valid),
    .res_o        (res_data),
    .res_ready_i  (!res_full)
  );

  sfd_fifo #(
    .Depth  (QDepth),
    .data_t (out_item_t)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule

>>> hdl/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks for the telemetry deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker
  import sfd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      pop,
  input logic      empty,
  input out_item_t out_data_o
);

  // A waiting result that is not taken stays in place unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result changed while waiting");

  // With no pending result the parser drains the byte queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(empty) && !$past(push)) |-> !full)
    else $error("full held while parser was free to drain");

  // Leaving reset, the result queue is empty and the byte queue is not full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

bind smartport_frame_deframer_unit sfd_checker u_sfd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .out_data_o (out_data_o)
);
